>>> rtl/string_gibberish_ngram_scorer_defines.svh
// assertion macros used by the checker file
`ifndef STRING_GIBBERISH_NGRAM_SCORER_DEFINES_SVH
`define STRING_GIBBERISH_NGRAM_SCORER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SGNS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SGNS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sgns_pkg.sv
// shared types, constants and helpers for the gibberish n-gram scorer
`timescale 1ns / 1ps

package sgns_pkg;

    localparam int TABLE_DEPTH_DEF  = 16384;
    localparam int MAX_STORED_DEF   = 16;
    localparam int WEIGHT_WIDTH_DEF = 16;

    localparam int IDX_W      = 14;
    localparam int VAL_W      = 16;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 5;
    localparam int SCORE_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_DEPTH  = 8;

    localparam logic [CHAR_W-1:0] LATIN_LO = 8'h09;
    localparam logic [CHAR_W-1:0] LATIN_HI = 8'h7E;
    localparam int NGRAM_SPAN = 118;

    localparam logic [IDX_W-1:0] SLOT_LENGTH   = 14'd14160;
    localparam logic [IDX_W-1:0] SLOT_NONLATIN = 14'd14161;
    localparam logic [IDX_W-1:0] SLOT_DISTINCT = 14'd14162;

    localparam logic [CNT_W-1:0] COUNT_CAP   = 5'd17;
    localparam logic [CNT_W-1:0] MIN_LEN_RST = 5'd4;
    localparam logic [CNT_W-1:0] MAX_LEN_RST = 5'd16;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 24'h7FFFFF;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 24'h800000;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_BYTE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CLASS_SCORED = 2'd0,
        CLASS_SHORT  = 2'd1,
        CLASS_LONG   = 2'd2
    } length_class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS       = 2'd0,
        REG_MIN_LENGTH = 2'd1,
        REG_MAX_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic is_latin(logic [CHAR_W-1:0] c);
        return (c >= LATIN_LO) && (c <= LATIN_HI);
    endfunction

endpackage

>>> rtl/sgns_seen_cell.sv
// one cell of the seen-byte chain: holds a byte, compares it, shifts to the next cell
`timescale 1ns / 1ps

module sgns_seen_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sgns_pkg::cell_ctrl_t           ctrl,
    input  logic [sgns_pkg::CHAR_W-1:0]    probe,
    input  logic [sgns_pkg::CHAR_W-1:0]    in_byte,
    input  logic                           in_used,
    output logic [sgns_pkg::CHAR_W-1:0]    out_byte,
    output logic                           out_used,
    output logic                           hit
);

    logic [sgns_pkg::CHAR_W-1:0] byte_reg;
    logic                        used_reg;
    logic                        used_next;

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            used_next = in_used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= in_byte;
        end
    end

    assign out_byte = byte_reg;
    assign out_used = used_reg;
    assign hit      = used_reg && (byte_reg == probe);

endmodule

>>> rtl/sgns_weight_mem.sv
// weight table: one write port, two registered read ports
`timescale 1ns / 1ps

module sgns_weight_mem #(
    parameter int DEPTH  = sgns_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH  = sgns_pkg::WEIGHT_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_a <= mem_array[raddr_a];
        rdata_b <= mem_array[raddr_b];
    end

endmodule

>>> rtl/sgns_out_fifo.sv
// result queue between the scoring pipeline and the master side
`timescale 1ns / 1ps

module sgns_out_fifo #(
    parameter int DEPTH = sgns_pkg::OUT_DEPTH,
    parameter int WIDTH = sgns_pkg::OUT_DATA_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_tdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/string_gibberish_ngram_scorer.sv
// top level of the string gibberish n-gram scorer
//
// slave side: one word per item; tuser selects a weight load (0) or a string
// byte (1), tlast marks the final byte of a string. loads write the weight
// table (unigrams, bigrams, then the length, non-latin and distinct slots).
// master side: one word per string, issued for its final byte only. an item
// is taken every cycle while s_tready is high. the rate is set by the two
// table read ports, which serve unigram and bigram in the same cycle, and by
// the row of seen-byte cells, probed per byte, shifted for unseen bytes
// while a cell is free. the cfg port sets bias, min_length and max_length;
// the user writes them only while no string is in flight, not enforced by
// the block. at reset the scalar weights and per-string state clear and the
// registers take their defaults; table entries hold nothing until loaded.
// up to eight results may be pending; while the receiver stalls they wait in
// the queue, and once eight are pending s_tready drops until one leaves.
`timescale 1ns / 1ps

module string_gibberish_ngram_scorer #(
    parameter int TABLE_DEPTH  = sgns_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_STORED   = sgns_pkg::MAX_STORED_DEF,
    parameter int WEIGHT_WIDTH = sgns_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // weight_index, weight_value, char_byte, zero fill
    input  logic [sgns_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // score, interesting, length_class, char_count
    output logic [sgns_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [sgns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgns_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int DELTA_W = WEIGHT_WIDTH + 2;
    localparam int SUM_W   = ((DELTA_W > sgns_pkg::SCORE_W) ? DELTA_W : sgns_pkg::SCORE_W) + 1;
    localparam int FSUM_W  = sgns_pkg::SCORE_W + 1;
    localparam int PEND_W  = $clog2(sgns_pkg::OUT_DEPTH + 1);
    localparam int CW      = sgns_pkg::CHAR_W;
    localparam int NW      = sgns_pkg::CNT_W;
    localparam int SW      = sgns_pkg::SCORE_W;

    // input unpacking
    logic [sgns_pkg::IDX_W-1:0]        weight_index;
    logic signed [sgns_pkg::VAL_W-1:0] weight_value;
    logic [CW-1:0]                     char_byte;

    assign weight_index = s_tdata[13:0];
    assign weight_value = s_tdata[29:14];
    assign char_byte    = s_tdata[37:30];

    logic accept, load_acc, byte_acc;

    assign accept   = s_tvalid && s_tready;
    assign load_acc = accept && (s_tuser == sgns_pkg::OP_LOAD);
    assign byte_acc = accept && (s_tuser == sgns_pkg::OP_BYTE);

    // configuration registers
    logic signed [sgns_pkg::VAL_W-1:0] bias_reg;
    logic [NW-1:0]                     min_len_reg;
    logic [NW-1:0]                     max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg    <= '0;
            min_len_reg <= sgns_pkg::MIN_LEN_RST;
            max_len_reg <= sgns_pkg::MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (sgns_pkg::reg_index_t'(cfg_index))
                sgns_pkg::REG_BIAS:       bias_reg    <= cfg_data;
                sgns_pkg::REG_MIN_LENGTH: min_len_reg <= cfg_data[NW-1:0];
                sgns_pkg::REG_MAX_LENGTH: max_len_reg <= cfg_data[NW-1:0];
                default:                  ;
            endcase
        end
    end

    // weight fitting
    logic signed [WEIGHT_WIDTH-1:0] wfit;

    generate
        if (WEIGHT_WIDTH >= sgns_pkg::VAL_W)
        begin : g_wide
            assign wfit = WEIGHT_WIDTH'(weight_value);
        end
        else
        begin : g_narrow
            logic [sgns_pkg::VAL_W-WEIGHT_WIDTH:0] upper;
            assign upper = weight_value[sgns_pkg::VAL_W-1:WEIGHT_WIDTH-1];
            always_comb
            begin
                if ((&upper) || (~|upper))
                begin
                    wfit = weight_value[WEIGHT_WIDTH-1:0];
                end
                else if (weight_value[sgns_pkg::VAL_W-1])
                begin
                    wfit = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
                end
                else
                begin
                    wfit = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
                end
            end
        end
    endgenerate

    // table writes and scalar weights
    logic mem_we;
    logic signed [WEIGHT_WIDTH-1:0] length_w_reg, nonlatin_w_reg, distinct_w_reg;

    assign mem_we = load_acc && (int'(weight_index) < TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_w_reg   <= '0;
            nonlatin_w_reg <= '0;
            distinct_w_reg <= '0;
        end
        else if (mem_we)
        begin
            if (weight_index == sgns_pkg::SLOT_LENGTH)
            begin
                length_w_reg <= wfit;
            end
            if (weight_index == sgns_pkg::SLOT_NONLATIN)
            begin
                nonlatin_w_reg <= wfit;
            end
            if (weight_index == sgns_pkg::SLOT_DISTINCT)
            begin
                distinct_w_reg <= wfit;
            end
        end
    end

    // per-string state
    logic [CW-1:0] prev_byte_reg, prev_byte_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [NW-1:0] count_reg, count_next, count_inc;

    logic          c_latin, bigram_en;
    logic [CW-1:0] char_off, prev_off;
    logic [ADDR_W-1:0] uni_addr, bi_addr;

    assign c_latin   = sgns_pkg::is_latin(char_byte);
    assign bigram_en = c_latin && prev_valid_reg && sgns_pkg::is_latin(prev_byte_reg);
    assign char_off  = char_byte - sgns_pkg::LATIN_LO;
    assign prev_off  = prev_byte_reg - sgns_pkg::LATIN_LO;
    assign count_inc = (count_reg == sgns_pkg::COUNT_CAP) ? count_reg : count_reg + 1'b1;

    assign uni_addr = c_latin ? ADDR_W'(char_off[6:0]) : '0;
    assign bi_addr  = bigram_en
                    ? ADDR_W'(sgns_pkg::NGRAM_SPAN) + ADDR_W'(prev_off[6:0])
                      + ADDR_W'(char_off[6:0]) * ADDR_W'(sgns_pkg::NGRAM_SPAN)
                    : '0;

    always_comb
    begin
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        count_next      = count_reg;
        if (byte_acc)
        begin
            if (s_tlast)
            begin
                prev_byte_next  = '0;
                prev_valid_next = 1'b0;
                count_next      = '0;
            end
            else
            begin
                prev_byte_next  = char_byte;
                prev_valid_next = 1'b1;
                count_next      = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            count_reg      <= count_next;
        end
    end

    // seen-byte chain
    logic [CW-1:0]         cell_byte [MAX_STORED];
    logic [MAX_STORED-1:0] cell_used;
    logic [MAX_STORED-1:0] cell_hit;
    logic                  fresh;
    sgns_pkg::cell_ctrl_t  cell_ctrl;

    assign fresh           = !cell_used[MAX_STORED-1] && !(|cell_hit);
    assign cell_ctrl.shift = byte_acc && fresh;
    assign cell_ctrl.clear = byte_acc && s_tlast;

    generate
        for (genvar i = 0; i < MAX_STORED; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                sgns_seen_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .probe    (char_byte),
                    .in_byte  (char_byte),
                    .in_used  (1'b1),
                    .out_byte (cell_byte[i]),
                    .out_used (cell_used[i]),
                    .hit      (cell_hit[i])
                );
            end
            else
            begin : g_body
                sgns_seen_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .probe    (char_byte),
                    .in_byte  (cell_byte[i-1]),
                    .in_used  (cell_used[i-1]),
                    .out_byte (cell_byte[i]),
                    .out_used (cell_used[i]),
                    .hit      (cell_hit[i])
                );
            end
        end
    endgenerate

    // weight table
    logic signed [WEIGHT_WIDTH-1:0] uni_w, bi_w;

    sgns_weight_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (WEIGHT_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_weight_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (ADDR_W'(weight_index)),
        .wdata   (wfit),
        .raddr_a (uni_addr),
        .raddr_b (bi_addr),
        .rdata_a (uni_w),
        .rdata_b (bi_w)
    );

    // stage 1: table read in flight, scalar weights taken with the byte
    logic                      s1_valid_reg;
    logic                      s1_latin_reg, s1_bigram_reg, s1_last_reg;
    logic [NW-1:0]             s1_count_reg;
    logic signed [DELTA_W-1:0] s1_part_reg, s1_part_next;

    always_comb
    begin
        s1_part_next = DELTA_W'(length_w_reg)
                     + (c_latin ? {DELTA_W{1'b0}} : DELTA_W'(nonlatin_w_reg))
                     + (fresh ? DELTA_W'(distinct_w_reg) : {DELTA_W{1'b0}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= byte_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_latin_reg  <= c_latin;
        s1_bigram_reg <= bigram_en;
        s1_last_reg   <= s_tlast;
        s1_count_reg  <= count_inc;
        s1_part_reg   <= s1_part_next;
    end

    // stage 2: per-byte weight sum
    logic                           s2_valid_reg;
    logic signed [DELTA_W-1:0]      s2_delta_reg, s2_delta_next;
    logic                           s2_last_reg;
    logic [NW-1:0]                  s2_count_reg;

    always_comb
    begin
        s2_delta_next = s1_part_reg
                      + (s1_latin_reg ? DELTA_W'(uni_w) : {DELTA_W{1'b0}})
                      + (s1_bigram_reg ? DELTA_W'(bi_w) : {DELTA_W{1'b0}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_delta_reg <= s2_delta_next;
        s2_last_reg  <= s1_last_reg;
        s2_count_reg <= s1_count_reg;
    end

    // stage 3: saturating accumulator
    logic signed [SW-1:0]    acc_reg, acc_next, acc_sat;
    logic signed [SUM_W-1:0] acc_sum;
    logic [SUM_W-SW:0]       acc_top;
    logic                    s3_valid_reg;
    logic signed [SW-1:0]    s3_sum_reg;
    logic [NW-1:0]           s3_count_reg;

    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(s2_delta_reg);
    assign acc_top = acc_sum[SUM_W-1:SW-1];

    always_comb
    begin
        if ((&acc_top) || (~|acc_top))
        begin
            acc_sat = acc_sum[SW-1:0];
        end
        else if (acc_sum[SUM_W-1])
        begin
            acc_sat = sgns_pkg::SCORE_MIN;
        end
        else
        begin
            acc_sat = sgns_pkg::SCORE_MAX;
        end
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_last_reg ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sum_reg   <= acc_sat;
        s3_count_reg <= s2_count_reg;
    end

    // final score, class and flag
    logic signed [FSUM_W-1:0] fsum;
    logic signed [SW-1:0]     score;
    logic [1:0]               fsum_top;
    logic                     interesting;
    sgns_pkg::length_class_t  length_class;

    assign fsum     = FSUM_W'(s3_sum_reg) + FSUM_W'(bias_reg);
    assign fsum_top = fsum[FSUM_W-1:SW-1];

    always_comb
    begin
        if ((&fsum_top) || (~|fsum_top))
        begin
            score = fsum[SW-1:0];
        end
        else if (fsum[FSUM_W-1])
        begin
            score = sgns_pkg::SCORE_MIN;
        end
        else
        begin
            score = sgns_pkg::SCORE_MAX;
        end
        if (s3_count_reg > max_len_reg)
        begin
            length_class = sgns_pkg::CLASS_LONG;
            interesting  = 1'b1;
        end
        else if (s3_count_reg < min_len_reg)
        begin
            length_class = sgns_pkg::CLASS_SHORT;
            interesting  = 1'b0;
        end
        else
        begin
            length_class = sgns_pkg::CLASS_SCORED;
            interesting  = !score[SW-1] && (score != '0);
        end
    end

    // pending result credit
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              pend_inc, pend_dec;

    assign pend_inc = byte_acc && s_tlast;
    assign pend_dec = m_tvalid && m_tready;
    assign s_tready = (pend_reg < PEND_W'(sgns_pkg::OUT_DEPTH));

    always_comb
    begin
        pend_next = pend_reg;
        if (pend_inc && !pend_dec)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (pend_dec && !pend_inc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    sgns_out_fifo #(
        .DEPTH (sgns_pkg::OUT_DEPTH),
        .WIDTH (sgns_pkg::OUT_DATA_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data ({s3_count_reg, length_class, interesting, score}),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/sgns_checker.sv
// port-level checker for the scorer, bound to the top level
`timescale 1ns / 1ps
`include "string_gibberish_ngram_scorer_defines.svh"

module sgns_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sgns_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    `SGNS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a new result follows a final string byte by the pipeline depth
    `SGNS_ASSERT_IMP(a_out_after_last, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast && (s_tuser == sgns_pkg::OP_BYTE), 4), "result without final byte")

    // input is held off only while results wait
    `SGNS_ASSERT_IMP(a_stall_has_output, !s_tready, m_tvalid, "input stalled with empty queue")

endmodule

bind string_gibberish_ngram_scorer sgns_checker u_sgns_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
